@@ hdl/pva_pkg.sv @@
package pva_pkg;

    localparam int VOICES_DEF = 8;

    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;
    localparam int REM_W  = 8;
    localparam int STAT_W = 8;
    localparam int CHAN_W = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_LENGTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEGATO           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_VELOCITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICES_ACTIVE    = 3'd4;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_NOTE = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [STAT_W-1:0] STATUS_NOTE_OFF = 8'h80;

    localparam logic [REM_W-1:0]  RST_NOTE_LENGTH      = 8'd8;
    localparam logic [VEL_W-1:0]  RST_RELEASE_VELOCITY = 7'd96;

    typedef struct packed {
        logic [1:0]        action;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status_byte;
        logic [NOTE_W-1:0] note_out;
        logic [VEL_W-1:0]  velocity_out;
        logic              last;
    } evt_t;

    typedef struct packed {
        logic [REM_W-1:0]  note_length;
        logic              legato;
        logic [CHAN_W-1:0] midi_channel;
        logic [VEL_W-1:0]  release_velocity;
        logic              voices_active;
    } cfg_t;

    typedef struct packed {
        logic              used;
        logic [NOTE_W-1:0] note;
        logic [REM_W-1:0]  remaining;
    } slot_t;

    // One MIDI event leaving the sequencer, before its last flag is known.
    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status_byte;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } emit_t;

    typedef struct packed {
        logic emit_ok;
        logic hold_valid;
        logic out_free;
    } out_status_t;

    function automatic logic [STAT_W-1:0] status_of(input logic [STAT_W-1:0] kind,
                                                    input logic [CHAN_W-1:0] chan);
        status_of = kind | {{(STAT_W-CHAN_W){1'b0}}, chan};
    endfunction

endpackage

@@ hdl/pva_slots.sv @@
module pva_slots
    import pva_pkg::*;
#(
    parameter int VOICES = VOICES_DEF,
    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_idx,
    output slot_t            rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  slot_t            wr_data
);

    logic              used_reg [VOICES];
    logic [NOTE_W-1:0] note_reg [VOICES];
    logic [REM_W-1:0]  rem_reg  [VOICES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                used_reg[i] <= 1'b0;
            end
        end
        else if (wr_en)
        begin
            used_reg[wr_idx] <= wr_data.used;
        end
    end

    // Note and count of a free slot are never looked at, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            note_reg[wr_idx] <= wr_data.note;
            rem_reg[wr_idx]  <= wr_data.remaining;
        end
    end

    assign rd_data.used      = used_reg[rd_idx];
    assign rd_data.note      = note_reg[rd_idx];
    assign rd_data.remaining = rem_reg[rd_idx];

endmodule

@@ hdl/pva_out.sv @@
module pva_out
    import pva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  emit_t       ev,
    input  logic        flush,
    input  logic        evt_stall,
    output logic        evt_valid,
    output evt_t        evt_data,
    output out_status_t st
);

    // One event is held back until the next one shows whether it was the last.
    logic  hold_valid_reg;
    emit_t hold_reg;
    logic  out_valid_reg;
    evt_t  out_reg;
    logic  out_free;

    assign out_free      = !out_valid_reg || !evt_stall;
    assign st.out_free   = out_free;
    assign st.hold_valid = hold_valid_reg;
    assign st.emit_ok    = !hold_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (ev.valid)
        begin
            hold_valid_reg <= 1'b1;
            if (hold_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (flush)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev.valid)
        begin
            hold_reg <= ev;
        end
        if ((ev.valid && hold_valid_reg) || flush)
        begin
            out_reg.status_byte  <= hold_reg.status_byte;
            out_reg.note_out     <= hold_reg.note;
            out_reg.velocity_out <= hold_reg.velocity;
            out_reg.last         <= flush;
        end
    end

    assign evt_valid = out_valid_reg;
    assign evt_data  = out_reg;

endmodule

@@ hdl/pva_seq.sv @@
module pva_seq
    import pva_pkg::*;
#(
    parameter int VOICES = VOICES_DEF,
    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req_data,
    input  cfg_t             cfg,
    output logic [IDX_W-1:0] rd_idx,
    input  slot_t            rd_data,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_idx,
    output slot_t            wr_data,
    output emit_t            ev,
    output logic             flush,
    input  out_status_t      st
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_TICK   = 9'b000000010,
        S_STOP   = 9'b000000100,
        S_MATCH  = 9'b000001000,
        S_MDEC   = 9'b000010000,
        S_ALLOC  = 9'b000100000,
        S_ADEC   = 9'b001000000,
        S_PLACE  = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [NOTE_W-1:0] note_reg, note_next;
    logic [VEL_W-1:0]  vel_reg, vel_next;
    logic              match_found_reg, match_found_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]  min_idx_reg, min_idx_next;
    logic [REM_W-1:0]  min_rem_reg, min_rem_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;

    logic [REM_W-1:0]  cmp_a, cmp_b;
    logic              cmp_eq, cmp_lt;
    logic              last_slot;
    logic              step;
    state_t            scan_done;

    assign req_stall = (state_reg != S_IDLE);
    assign rd_idx    = (state_reg == S_ADEC) ? min_idx_reg : idx_reg;
    assign last_slot = (idx_reg == LAST_IDX);

    // The one comparator, shared by the tick, match and allocation scans.
    always_comb
    begin
        case (state_reg)
            S_MATCH:
            begin
                cmp_a = {1'b0, rd_data.note};
                cmp_b = {1'b0, note_reg};
            end
            S_ALLOC:
            begin
                cmp_a = rd_data.remaining;
                cmp_b = min_rem_reg;
            end
            default:
            begin
                cmp_a = rd_data.remaining;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_lt = (cmp_a < cmp_b);

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        note_next        = note_reg;
        vel_next         = vel_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        min_idx_next     = min_idx_reg;
        min_rem_next     = min_rem_reg;
        tgt_next         = tgt_reg;
        wr_en            = 1'b0;
        wr_idx           = idx_reg;
        wr_data          = '0;
        ev               = '0;
        flush            = 1'b0;
        step             = 1'b1;
        scan_done        = S_FINISH;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    note_next        = req_data.note;
                    vel_next         = req_data.velocity;
                    match_found_next = 1'b0;
                    idx_next         = '0;
                    case (req_data.action)
                        ACT_TICK: state_next = cfg.voices_active ? S_TICK : S_FINISH;
                        ACT_NOTE: state_next = S_MATCH;
                        ACT_STOP: state_next = S_STOP;
                        default:  state_next = S_FINISH;
                    endcase
                end
                step = 1'b0;
            end
            S_TICK:
            begin
                if (rd_data.used)
                begin
                    if (cmp_eq)
                    begin
                        if (st.emit_ok)
                        begin
                            ev.valid       = 1'b1;
                            ev.status_byte = status_of(STATUS_NOTE_OFF, cfg.midi_channel);
                            ev.note        = rd_data.note;
                            ev.velocity    = cfg.release_velocity;
                            wr_en          = 1'b1;
                        end
                        else
                        begin
                            step = 1'b0;
                        end
                    end
                    else
                    begin
                        wr_en             = 1'b1;
                        wr_data           = rd_data;
                        wr_data.remaining = rd_data.remaining - REM_W'(1);
                    end
                end
            end
            S_STOP:
            begin
                if (rd_data.used)
                begin
                    if (st.emit_ok)
                    begin
                        ev.valid       = 1'b1;
                        ev.status_byte = status_of(STATUS_NOTE_OFF, cfg.midi_channel);
                        ev.note        = rd_data.note;
                        ev.velocity    = cfg.release_velocity;
                        wr_en          = 1'b1;
                    end
                    else
                    begin
                        step = 1'b0;
                    end
                end
            end
            S_MATCH:
            begin
                // A later match wins, as with duplicates the highest slot is taken.
                if (rd_data.used && cmp_eq)
                begin
                    match_found_next = 1'b1;
                    match_idx_next   = idx_reg;
                end
                scan_done = S_MDEC;
            end
            S_MDEC:
            begin
                step = 1'b0;
                if (!match_found_reg)
                begin
                    state_next      = S_ALLOC;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                end
                else if (cfg.legato)
                begin
                    wr_en             = 1'b1;
                    wr_idx            = match_idx_reg;
                    wr_data.used      = 1'b1;
                    wr_data.note      = note_reg;
                    wr_data.remaining = cfg.note_length;
                    state_next        = S_FINISH;
                end
                else if (st.emit_ok)
                begin
                    ev.valid        = 1'b1;
                    ev.status_byte  = status_of(STATUS_NOTE_OFF, cfg.midi_channel);
                    ev.note         = note_reg;
                    ev.velocity     = vel_reg;
                    wr_en           = 1'b1;
                    wr_idx          = match_idx_reg;
                    state_next      = S_ALLOC;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                end
            end
            S_ALLOC:
            begin
                if (!rd_data.used && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if ((idx_reg == '0) || cmp_lt)
                begin
                    min_idx_next = idx_reg;
                    min_rem_next = rd_data.remaining;
                end
                scan_done = S_ADEC;
            end
            S_ADEC:
            begin
                step = 1'b0;
                if (free_found_reg)
                begin
                    tgt_next   = free_idx_reg;
                    state_next = S_PLACE;
                end
                else if (st.emit_ok)
                begin
                    ev.valid       = 1'b1;
                    ev.status_byte = status_of(STATUS_NOTE_OFF, cfg.midi_channel);
                    ev.note        = rd_data.note;
                    ev.velocity    = cfg.release_velocity;
                    tgt_next       = min_idx_reg;
                    state_next     = S_PLACE;
                end
            end
            S_PLACE:
            begin
                step = 1'b0;
                if (st.emit_ok)
                begin
                    wr_en             = 1'b1;
                    wr_idx            = tgt_reg;
                    wr_data.used      = 1'b1;
                    wr_data.note      = note_reg;
                    wr_data.remaining = cfg.note_length;
                    ev.valid          = 1'b1;
                    ev.status_byte    = status_of(STATUS_NOTE_ON, cfg.midi_channel);
                    ev.note           = note_reg;
                    ev.velocity       = vel_reg;
                    state_next        = S_FINISH;
                end
            end
            S_FINISH:
            begin
                step = 1'b0;
                if (!st.hold_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (st.out_free)
                begin
                    flush      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                step       = 1'b0;
                state_next = S_IDLE;
            end
        endcase

        if (step)
        begin
            if (last_slot)
            begin
                state_next = scan_done;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        note_reg        <= note_next;
        vel_reg         <= vel_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        min_idx_reg     <= min_idx_next;
        min_rem_reg     <= min_rem_next;
        tgt_reg         <= tgt_next;
    end

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        ev.valid |-> st.emit_ok)
        else $error("event issued while the output path is full");

    a_emit_flush_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(ev.valid && flush))
        else $error("event and flush in the same cycle");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_idx <= LAST_IDX))
        else $error("slot write beyond the table");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted without entering a scan");

endmodule

@@ hdl/poly_voice_allocator_top.sv @@
// Polyphonic voice allocator producing MIDI note-on and note-off events.
//
// Requests arrive on req_valid / req_stall / req_data (action, note, velocity);
// a request is taken on a rising edge with req_valid high and req_stall low.
// Each request yields zero or more events on evt_valid / evt_stall / evt_data,
// in order, with last set on the final event of that request.
// Configuration is written on cfg_valid / cfg_ready (always ready), with
// cfg_index selecting the register; write it only while the block is idle.
//
// One request is handled at a time by a sequencer that walks the slot table
// one slot per cycle, unless a held-up event makes it wait, through a single
// shared comparator. A tick or stop-all scans the table once (not at all when
// ticks are frozen or the action is unused). A note request scans it twice
// (match, then free or steal search); a legato retrigger needs only the match.
// Stalls on the event side stretch a request, since one event is held
// back until the next shows whether it is the last.
// Reset frees every slot and loads the register defaults; no clearing pass
// is needed. When the receiver stalls, the current event holds steady and
// the sequencer waits as soon as a further event has nowhere to go.
module poly_voice_allocator_top
    import pva_pkg::*;
#(
    parameter int VOICES = VOICES_DEF,
    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req_data,
    output logic                  evt_valid,
    input  logic                  evt_stall,
    output evt_t                  evt_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t             cfg_reg;
    logic [IDX_W-1:0] rd_idx;
    slot_t            rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    slot_t            wr_data;
    emit_t            ev;
    logic             flush;
    out_status_t      st;

    // The register file never pushes back; writes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.note_length      <= RST_NOTE_LENGTH;
            cfg_reg.legato           <= 1'b0;
            cfg_reg.midi_channel     <= '0;
            cfg_reg.release_velocity <= RST_RELEASE_VELOCITY;
            cfg_reg.voices_active    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NOTE_LENGTH:      cfg_reg.note_length      <= cfg_data[REM_W-1:0];
                CFG_LEGATO:           cfg_reg.legato           <= cfg_data[0];
                CFG_MIDI_CHANNEL:     cfg_reg.midi_channel     <= cfg_data[CHAN_W-1:0];
                CFG_RELEASE_VELOCITY: cfg_reg.release_velocity <= cfg_data[VEL_W-1:0];
                CFG_VOICES_ACTIVE:    cfg_reg.voices_active    <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    pva_seq #(
        .VOICES (VOICES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .cfg       (cfg_reg),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .ev        (ev),
        .flush     (flush),
        .st        (st)
    );

    pva_slots #(
        .VOICES (VOICES)
    ) u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data)
    );

    pva_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev        (ev),
        .flush     (flush),
        .evt_stall (evt_stall),
        .evt_valid (evt_valid),
        .evt_data  (evt_data),
        .st        (st)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the polyphonic voice allocator.
//
// A driver and a monitor run as clocked always blocks. The driver feeds requests
// from a queue that the stimulus process fills. The monitor samples both
// handshakes on the rising edge. For each accepted request it runs a
// behavioral copy of the slot table, which queues the MIDI events that request
// must produce. Each event the block hands over is checked against the oldest
// queued event. Configuration is written only while the block is idle, between
// phases, and the bench keeps its own copy of the registers.
module tb_top;

    import pva_pkg::*;

    localparam int VOICES = VOICES_DEF;
    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 8;
    // Waiting this long after the last event lets a request that makes no events
    // finish before a register write.
    localparam int DRAIN_CYCLES = 4 * VOICES + 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 42;
    localparam int NOTE_POOL = 12;

    // Action code 3 is not decoded by the block. It must be swallowed silently.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req_data = '0;
    logic                  evt_valid;
    logic                  evt_stall = 1'b0;
    evt_t                  evt_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    poly_voice_allocator_top #(.VOICES(VOICES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_data  (evt_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // These are the requests waiting for the driver, and the events the
    // behavioral slot table says are still owed by the block.
    req_t pending_reqs[$];
    evt_t midi_expected[$];

    // This is the bench's own copy of the registers and of the voice table.
    cfg_t              shadow_cfg;
    logic              voice_used[VOICES];
    logic [NOTE_W-1:0] voice_note[VOICES];
    logic [REM_W-1:0]  voice_left[VOICES];

    int   reqs_sent = 0;
    int   reqs_taken = 0;
    int   cfg_writes = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   req_gap = 0;
    int   stall_left = 0;
    logic req_fire = 1'b0;
    logic quiet = 1'b0;
    evt_t oldest_evt;

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // The watchdog ends the run if the block hangs or loses a request.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // This builds one MIDI event. The status byte carries the current channel in its
    // low nibble. The last flag is filled in once the whole batch is known.
    function automatic evt_t midi_event(input logic [STAT_W-1:0] kind,
                                        input logic [NOTE_W-1:0] n,
                                        input logic [VEL_W-1:0] v);
        evt_t e;
        e.status_byte  = kind | {4'h0, shadow_cfg.midi_channel};
        e.note_out     = n;
        e.velocity_out = v;
        e.last         = 1'b0;
        return e;
    endfunction

    // This applies one request to the voice table and queues the events it
    // causes, in the order the block must send them.
    task automatic allocate_voices(input req_t r);
        evt_t batch[$];
        int   hit;
        int   slot;
        int   i;
        hit  = -1;
        slot = -1;
        case (r.action)
            ACT_TICK:
            begin
                if (shadow_cfg.voices_active)
                begin
                    for (i = 0; i < VOICES; i++)
                    begin
                        if (voice_used[i])
                        begin
                            // A voice already at zero is released on this
                            // tick. Any other voice counts down by one.
                            if (voice_left[i] == 0)
                            begin
                                batch.push_back(midi_event(STATUS_NOTE_OFF, voice_note[i],
                                                           shadow_cfg.release_velocity));
                                voice_used[i] = 1'b0;
                                voice_note[i] = '0;
                            end
                            else
                            begin
                                voice_left[i] = voice_left[i] - 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_NOTE:
            begin
                // On duplicate matches the highest index wins.
                for (i = 0; i < VOICES; i++)
                begin
                    if (voice_used[i] && voice_note[i] == r.note)
                    begin
                        hit = i;
                    end
                end
                if (hit >= 0 && shadow_cfg.legato)
                begin
                    // A legato retrigger only reloads the length and sends nothing.
                    voice_left[hit] = shadow_cfg.note_length;
                    return;
                end
                if (hit >= 0)
                begin
                    batch.push_back(midi_event(STATUS_NOTE_OFF, r.note, r.velocity));
                    voice_used[hit] = 1'b0;
                    voice_note[hit] = '0;
                    voice_left[hit] = '0;
                end
                for (i = 0; i < VOICES && slot < 0; i++)
                begin
                    if (!voice_used[i])
                    begin
                        slot = i;
                    end
                end
                if (slot < 0)
                begin
                    // With the table full, the voice with the least time left is
                    // stolen. The lowest index wins a tie.
                    slot = 0;
                    for (i = 1; i < VOICES; i++)
                    begin
                        if (voice_left[i] < voice_left[slot])
                        begin
                            slot = i;
                        end
                    end
                    batch.push_back(midi_event(STATUS_NOTE_OFF, voice_note[slot],
                                               shadow_cfg.release_velocity));
                end
                voice_used[slot] = 1'b1;
                voice_note[slot] = r.note;
                voice_left[slot] = shadow_cfg.note_length;
                batch.push_back(midi_event(STATUS_NOTE_ON, r.note, r.velocity));
            end
            ACT_STOP:
            begin
                for (i = 0; i < VOICES; i++)
                begin
                    if (voice_used[i])
                    begin
                        batch.push_back(midi_event(STATUS_NOTE_OFF, voice_note[i],
                                                   shadow_cfg.release_velocity));
                        voice_used[i] = 1'b0;
                        voice_note[i] = '0;
                        voice_left[i] = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (batch.size() > 0)
        begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[k])
        begin
            midi_expected.push_back(batch[k]);
        end
    endtask

    // The monitor samples every handshake on the rising edge. The values it
    // reads were driven at the previous falling edge or registered by the block.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_cfg.note_length      = RST_NOTE_LENGTH;
            shadow_cfg.legato           = 1'b0;
            shadow_cfg.midi_channel     = '0;
            shadow_cfg.release_velocity = RST_RELEASE_VELOCITY;
            shadow_cfg.voices_active    = 1'b1;
            for (int i = 0; i < VOICES; i++)
            begin
                voice_used[i] = 1'b0;
                voice_note[i] = '0;
                voice_left[i] = '0;
            end
            req_fire <= 1'b0;
        end
        else
        begin
            req_fire <= req_valid && !req_stall;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NOTE_LENGTH:      shadow_cfg.note_length = cfg_data;
                    CFG_LEGATO:           shadow_cfg.legato = cfg_data[0];
                    CFG_MIDI_CHANNEL:     shadow_cfg.midi_channel = cfg_data[CHAN_W-1:0];
                    CFG_RELEASE_VELOCITY: shadow_cfg.release_velocity = cfg_data[VEL_W-1:0];
                    CFG_VOICES_ACTIVE:    shadow_cfg.voices_active = cfg_data[0];
                    default:
                    begin
                    end
                endcase
                cfg_writes++;
            end

            if (req_valid && !req_stall)
            begin
                allocate_voices(req_data);
                reqs_taken++;
            end

            if (evt_valid && !evt_stall)
            begin
                if (midi_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("t=%0t unexpected event: status=%h note=%0d vel=%0d last=%b",
                                 $realtime, evt_data.status_byte, evt_data.note_out,
                                 evt_data.velocity_out, evt_data.last);
                    end
                end
                else
                begin
                    oldest_evt = midi_expected.pop_front();
                    if (evt_data.status_byte !== oldest_evt.status_byte ||
                        evt_data.note_out !== oldest_evt.note_out ||
                        evt_data.velocity_out !== oldest_evt.velocity_out ||
                        evt_data.last !== oldest_evt.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("t=%0t event mismatch: exp status=%h note=%0d vel=%0d last=%b",
                                     $realtime, oldest_evt.status_byte, oldest_evt.note_out,
                                     oldest_evt.velocity_out, oldest_evt.last);
                            $display("                       got status=%h note=%0d vel=%0d last=%b",
                                     evt_data.status_byte, evt_data.note_out,
                                     evt_data.velocity_out, evt_data.last);
                        end
                    end
                end
            end
        end
    end

    // The request driver works on the falling edge. A request that is offered stays
    // put until it is taken. After a taken request a random gap may follow.
    // The quiet phase has no gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_fire)
            begin
                // The request is still stalled, so the payload holds.
            end
            else if (req_gap > 0)
            begin
                req_valid <= 1'b0;
                req_gap = req_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_data  <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                begin
                    req_gap = $urandom_range(1, 4);
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // The receiver stalls in random bursts, with open
    // stretches between them.
    always @(negedge clk)
    begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 4);
        end
        if (stall_left > 0)
        begin
            evt_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            evt_stall <= 1'b0;
        end
    end

    task automatic queue_request(input logic [1:0] act, input logic [NOTE_W-1:0] n,
                                 input logic [VEL_W-1:0] v);
        req_t r;
        r.action   = act;
        r.note     = n;
        r.velocity = v;
        pending_reqs.push_back(r);
        reqs_sent++;
    endtask

    // This waits until every queued request has been taken and every owed event
    // has arrived. It then lets the block finish a request that makes no events.
    task automatic wait_until_idle();
        do
        begin
            @(negedge clk);
        end
        while (reqs_taken != reqs_sent || midi_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        int seen;
        seen = cfg_writes;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
        end
        while (cfg_writes == seen);
        cfg_valid <= 1'b0;
    endtask

    // This queues a stream of mostly note requests and ticks. The notes are drawn
    // mostly from a small pool, so retriggers and steals happen often. Ignored
    // requests are sprinkled in as noise and do not count toward the total.
    task automatic queue_random_phase(input int count);
        int               made;
        int               pick;
        logic [NOTE_W-1:0] pool_base;
        logic [NOTE_W-1:0] n;
        made      = 0;
        pool_base = NOTE_W'($urandom_range(0, 127 - NOTE_POOL));
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0)
            begin
                n = NOTE_W'($urandom_range(0, 127));
            end
            else
            begin
                n = NOTE_W'(pool_base + $urandom_range(0, NOTE_POOL - 1));
            end
            if (pick < 52)
            begin
                queue_request(ACT_NOTE, n, VEL_W'($urandom_range(0, 127)));
                made++;
            end
            else if (pick < 92)
            begin
                queue_request(ACT_TICK, n, VEL_W'($urandom_range(0, 127)));
                made++;
            end
            else if (pick < 96)
            begin
                queue_request(ACT_STOP, n, VEL_W'($urandom_range(0, 127)));
                made++;
            end
            else
            begin
                queue_request(ACT_UNUSED, n, VEL_W'($urandom_range(0, 127)));
            end
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] len;
        logic [CFG_DATA_W-1:0] chan;
        logic [CFG_DATA_W-1:0] rel;

        @(posedge rst_n);

        // The first directed part runs with the reset defaults. It sends both
        // note and velocity extremes and fills every slot. A steal follows,
        // where all voices tie and slot 0 loses. Then come a plain retrigger, a
        // tick, an ignored action and a stop-all.
        queue_request(ACT_NOTE, 7'd0, 7'd127);
        queue_request(ACT_NOTE, 7'd127, 7'd0);
        for (int i = 0; i < VOICES - 2; i++)
        begin
            queue_request(ACT_NOTE, NOTE_W'(60 + i), 7'd64);
        end
        queue_request(ACT_NOTE, 7'd70, 7'd100);
        queue_request(ACT_NOTE, 7'd61, 7'd1);
        queue_request(ACT_TICK, 7'd0, 7'd0);
        queue_request(ACT_UNUSED, 7'd127, 7'd127);
        queue_request(ACT_STOP, 7'd0, 7'd0);
        wait_until_idle();

        // The second directed part uses zero length, legato, the top channel and
        // the top release velocity. A legato retrigger sends nothing. A
        // zero-length note is released on the very next tick.
        write_reg(CFG_NOTE_LENGTH, 8'd0);
        write_reg(CFG_LEGATO, 8'd1);
        write_reg(CFG_MIDI_CHANNEL, 8'd15);
        write_reg(CFG_RELEASE_VELOCITY, 8'd127);
        queue_request(ACT_NOTE, 7'd5, 7'd127);
        queue_request(ACT_NOTE, 7'd5, 7'd20);
        queue_request(ACT_TICK, 7'd0, 7'd0);
        queue_request(ACT_NOTE, 7'd33, 7'd77);
        queue_request(ACT_TICK, 7'd0, 7'd0);
        wait_until_idle();

        // With voices frozen, a tick does nothing but stop-all still releases.
        write_reg(CFG_VOICES_ACTIVE, 8'd0);
        write_reg(CFG_NOTE_LENGTH, 8'd3);
        queue_request(ACT_NOTE, 7'd3, 7'd50);
        queue_request(ACT_TICK, 7'd0, 7'd0);
        queue_request(ACT_STOP, 7'd0, 7'd0);
        wait_until_idle();

        // The random phases each get a fresh register setting. Certain phases
        // pin the extremes, and the upper data bits carry random noise that
        // the block must mask. Short note lengths keep releases frequent.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 2)
            begin
                len = 8'd255;
            end
            else if (p == 5)
            begin
                len = 8'd0;
            end
            else if (p == 4)
            begin
                len = 8'($urandom_range(0, 255));
            end
            else
            begin
                len = 8'($urandom_range(0, 12));
            end
            chan = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            rel  = (p == 3) ? 8'h7F : (p == 4) ? 8'h80 : 8'($urandom_range(0, 255));

            write_reg(CFG_NOTE_LENGTH, len);
            write_reg(CFG_LEGATO, {7'($urandom_range(0, 127)), p[0]});
            write_reg(CFG_MIDI_CHANNEL, chan);
            write_reg(CFG_RELEASE_VELOCITY, rel);
            write_reg(CFG_VOICES_ACTIVE, {7'($urandom_range(0, 127)), p != 6});
            // An index past the register list must be ignored.
            write_reg(CFG_IDX_W'(CFG_VOICES_ACTIVE + 1 + $urandom_range(0, 2)),
                      CFG_DATA_W'($urandom_range(0, 255)));

            // The final phase runs with no idling on either side.
            if (p == RANDOM_PHASES - 1)
            begin
                quiet = 1'b1;
            end
            queue_random_phase(ITEMS_PER_PHASE);
            wait_until_idle();
        end

        mismatch_count += midi_expected.size();
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/pva_pkg.sv
hdl/pva_slots.sv
hdl/pva_out.sv
hdl/pva_seq.sv
hdl/poly_voice_allocator_top.sv
tb/tb_top.sv
